[rtl/sia_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sia_pkg
// Operation and interval kind codes shared by the signed interval ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

    typedef logic [2:0] sia_action_t;
    typedef logic [1:0] sia_kind_t;

    localparam sia_action_t ACT_ADD   = 3'd0;
    localparam sia_action_t ACT_SUB   = 3'd1;
    localparam sia_action_t ACT_MUL   = 3'd2;
    localparam sia_action_t ACT_SDIV  = 3'd3;
    localparam sia_action_t ACT_UDIV  = 3'd4;
    localparam sia_action_t ACT_JOIN  = 3'd5;
    localparam sia_action_t ACT_OTHER = 3'd6;

    localparam sia_kind_t KIND_UNKNOWN   = 2'd0;
    localparam sia_kind_t KIND_BOUNDED   = 2'd1;
    localparam sia_kind_t KIND_UNBOUNDED = 2'd2;

    localparam int NUM_LANES = 4;

endpackage
`default_nettype wire

[rtl/sia_divpipe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sia_divpipe
// Unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sia_divpipe #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient
);
    logic [W-1:0] rem_reg  [W];
    logic [W-1:0] quo_reg  [W];
    logic [W-1:0] dvs_reg  [W];
    logic [W-1:0] rem_next [W];
    logic [W-1:0] quo_next [W];
    logic [W-1:0] dvs_next [W];

    always_comb
    begin
        logic [W-1:0] r_in;
        logic [W-1:0] q_in;
        logic [W-1:0] d_in;
        logic [W:0]   r_sh;
        logic         ge;
        for (int k = 0; k < W; k++)
        begin
            if (k == 0)
            begin
                r_in = '0;
                q_in = dividend;
                d_in = divisor;
            end
            else
            begin
                r_in = rem_reg[k-1];
                q_in = quo_reg[k-1];
                d_in = dvs_reg[k-1];
            end
            r_sh = {r_in, q_in[W-1]};
            ge   = (r_sh >= {1'b0, d_in});
            if (ge)
            begin
                r_sh = r_sh - {1'b0, d_in};
            end
            rem_next[k] = r_sh[W-1:0];
            quo_next[k] = {q_in[W-2:0], ge};
            dvs_next[k] = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dvs_reg[k] <= dvs_next[k];
            end
        end
    end

    assign quotient = quo_reg[W-1];

endmodule
`default_nettype wire

[rtl/sia_delay.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sia_delay
// Sideband delay line with a valid bit per stage, aligned to the divider.
// ----------------------------------------------------------------------------
module sia_delay #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire logic [DW-1:0] data_in,
    output logic               vld_out,
    output logic      [DW-1:0] data_out
);
    logic          vld_reg  [DEPTH];
    logic [DW-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= vld_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= data_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                data_reg[k] <= data_reg[k-1];
            end
        end
    end

    assign vld_out  = vld_reg[DEPTH-1];
    assign data_out = data_reg[DEPTH-1];

endmodule
`default_nettype wire

[rtl/signed_interval_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// signed_interval_alu
// Interval arithmetic over WIDTH-bit two's complement bounds.
// ----------------------------------------------------------------------------
// One request enters per cycle unless a stall holds it, and each result passes
// the input register, WIDTH divider stages and the result register; the depth
// is set by the bit-per-stage divider lanes; all operations take the same path.
// Add, subtract and join are resolved up front; multiply and both divides are
// resolved in the final stage. Overflow or a zero divisor gives unbounded.
// A result-side stall while out_valid is high holds the whole pipeline in place.
module signed_interval_alu #(
    parameter int WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         action,
    input  wire logic [1:0]         left_kind,
    input  wire logic signed [31:0] left_low,
    input  wire logic signed [31:0] left_high,
    input  wire logic [1:0]         right_kind,
    input  wire logic signed [31:0] right_low,
    input  wire logic signed [31:0] right_high,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              result_kind,
    output logic signed [31:0]      result_low,
    output logic signed [31:0]      result_high
);
    import sia_pkg::*;

    localparam int W = WIDTH;

    typedef struct packed {
        logic                       fixed;
        sia_action_t                act;
        sia_kind_t                  kind;
        logic [W-1:0]               lo;
        logic [W-1:0]               hi;
        logic [NUM_LANES-1:0][2*W-1:0] prod;
        logic [NUM_LANES-1:0]       sneg;
        logic [NUM_LANES-1:0]       minov;
        logic                       span;
        logic [W-1:0]               m;
        logic                       dz;
    } sia_side_t;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic lt_s(input logic [W-1:0] a, input logic [W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    logic         adv;
    logic         s0_vld_reg;
    sia_action_t  s0_act_reg;
    sia_kind_t    s0_lk_reg;
    sia_kind_t    s0_rk_reg;
    logic [W-1:0] s0_l1_reg;
    logic [W-1:0] s0_r1_reg;
    logic [W-1:0] s0_l2_reg;
    logic [W-1:0] s0_r2_reg;

    logic         out_vld_reg;
    sia_kind_t    res_kind_reg;
    logic [31:0]  res_lo_reg;
    logic [31:0]  res_hi_reg;
    sia_kind_t    res_kind_next;
    logic [W-1:0] res_lo_next;
    logic [W-1:0] res_hi_next;

    sia_side_t    side_in;
    sia_side_t    side_out;
    logic [$bits(sia_side_t)-1:0] side_out_bits;
    logic         side_vld;

    logic [W-1:0] dv_a [NUM_LANES];
    logic [W-1:0] dv_b [NUM_LANES];
    logic [W-1:0] dv_q [NUM_LANES];

    assign adv      = !out_vld_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_act_reg <= action;
            s0_lk_reg  <= (left_kind > KIND_UNBOUNDED) ? KIND_UNKNOWN : left_kind;
            s0_rk_reg  <= (right_kind > KIND_UNBOUNDED) ? KIND_UNKNOWN : right_kind;
            s0_l1_reg  <= W'(left_low);
            s0_r1_reg  <= W'(left_high);
            s0_l2_reg  <= W'(right_low);
            s0_r2_reg  <= W'(right_high);
        end
    end

    always_comb
    begin
        logic [W-1:0] ca [NUM_LANES];
        logic [W-1:0] cb [NUM_LANES];
        logic [W-1:0] sum_lo;
        logic [W-1:0] sum_hi;
        logic         ov;
        logic         both_b;
        logic         any_u;
        logic [W-1:0] ml1;
        logic [W-1:0] mr1;
        logic [W-1:0] smin;

        ca[0] = s0_l1_reg; cb[0] = s0_l2_reg;
        ca[1] = s0_l1_reg; cb[1] = s0_r2_reg;
        ca[2] = s0_r1_reg; cb[2] = s0_l2_reg;
        ca[3] = s0_r1_reg; cb[3] = s0_r2_reg;
        smin = {1'b1, {(W-1){1'b0}}};

        side_in = '0;
        side_in.act = s0_act_reg;
        both_b = (s0_lk_reg == KIND_BOUNDED) && (s0_rk_reg == KIND_BOUNDED);
        any_u  = (s0_lk_reg == KIND_UNBOUNDED) || (s0_rk_reg == KIND_UNBOUNDED);

        for (int i = 0; i < NUM_LANES; i++)
        begin
            side_in.prod[i]  = (2*W)'(mag_of(ca[i])) * (2*W)'(mag_of(cb[i]));
            side_in.sneg[i]  = ca[i][W-1] ^ cb[i][W-1];
            side_in.minov[i] = (ca[i] == smin) && (cb[i] == '1);
            if (s0_act_reg == ACT_UDIV)
            begin
                dv_a[i] = ca[i];
                dv_b[i] = cb[i];
            end
            else
            begin
                dv_a[i] = mag_of(ca[i]);
                dv_b[i] = mag_of(cb[i]);
            end
        end

        ml1 = mag_of(s0_l1_reg);
        mr1 = mag_of(s0_r1_reg);
        side_in.m    = (ml1 > mr1) ? ml1 : mr1;
        side_in.span = s0_l2_reg[W-1] && !s0_r2_reg[W-1] && (s0_r2_reg != '0);
        side_in.dz   = (s0_l2_reg == '0) || (s0_r2_reg == '0);

        if (s0_act_reg == ACT_SUB)
        begin
            sum_lo = s0_l1_reg - s0_r2_reg;
            sum_hi = s0_r1_reg - s0_l2_reg;
            ov = ((s0_l1_reg[W-1] != s0_r2_reg[W-1]) && (sum_lo[W-1] != s0_l1_reg[W-1]))
              || ((s0_r1_reg[W-1] != s0_l2_reg[W-1]) && (sum_hi[W-1] != s0_r1_reg[W-1]));
        end
        else
        begin
            sum_lo = s0_l1_reg + s0_l2_reg;
            sum_hi = s0_r1_reg + s0_r2_reg;
            ov = ((s0_l1_reg[W-1] == s0_l2_reg[W-1]) && (sum_lo[W-1] != s0_l1_reg[W-1]))
              || ((s0_r1_reg[W-1] == s0_r2_reg[W-1]) && (sum_hi[W-1] != s0_r1_reg[W-1]));
        end

        side_in.fixed = 1'b1;
        side_in.kind  = KIND_UNBOUNDED;
        if (s0_act_reg == ACT_JOIN)
        begin
            if (s0_lk_reg == KIND_UNKNOWN)
            begin
                side_in.kind = s0_rk_reg;
                side_in.lo   = s0_l2_reg;
                side_in.hi   = s0_r2_reg;
            end
            else if (s0_rk_reg == KIND_UNKNOWN)
            begin
                side_in.kind = s0_lk_reg;
                side_in.lo   = s0_l1_reg;
                side_in.hi   = s0_r1_reg;
            end
            else if (!any_u)
            begin
                side_in.kind = KIND_BOUNDED;
                side_in.lo   = lt_s(s0_l1_reg, s0_l2_reg) ? s0_l1_reg : s0_l2_reg;
                side_in.hi   = lt_s(s0_r2_reg, s0_r1_reg) ? s0_r1_reg : s0_r2_reg;
            end
        end
        else if (both_b)
        begin
            case (s0_act_reg)
                ACT_ADD, ACT_SUB:
                begin
                    if (!ov)
                    begin
                        side_in.kind = KIND_BOUNDED;
                        side_in.lo   = sum_lo;
                        side_in.hi   = sum_hi;
                    end
                end
                ACT_MUL, ACT_SDIV, ACT_UDIV:
                begin
                    side_in.fixed = 1'b0;
                end
                default:
                begin
                    side_in.kind = KIND_UNBOUNDED;
                end
            endcase
        end
        else if (!any_u)
        begin
            side_in.kind = KIND_UNKNOWN;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        sia_divpipe #(
            .W (W)
        ) u_div (
            .clk      (clk),
            .en       (adv),
            .dividend (dv_a[g]),
            .divisor  (dv_b[g]),
            .quotient (dv_q[g])
        );
    end

    sia_delay #(
        .DW    ($bits(sia_side_t)),
        .DEPTH (W)
    ) u_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .vld_in   (s0_vld_reg),
        .data_in  (side_in),
        .vld_out  (side_vld),
        .data_out (side_out_bits)
    );

    assign side_out = sia_side_t'(side_out_bits);

    always_comb
    begin
        logic [W-1:0] cv [NUM_LANES];
        logic [W-1:0] limit;
        logic [W-1:0] mn;
        logic [W-1:0] mx;
        logic         ov;
        logic         neg;

        ov    = 1'b0;
        neg   = 1'b0;
        limit = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (side_out.act == ACT_MUL)
            begin
                neg   = side_out.sneg[i] && (side_out.prod[i] != '0);
                limit = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                if ((side_out.prod[i][2*W-1:W] != '0) || (side_out.prod[i][W-1:0] > limit))
                begin
                    ov = 1'b1;
                end
                cv[i] = neg ? (~side_out.prod[i][W-1:0] + 1'b1) : side_out.prod[i][W-1:0];
            end
            else
            begin
                if (side_out.minov[i])
                begin
                    ov = 1'b1;
                end
                cv[i] = side_out.sneg[i] ? (~dv_q[i] + 1'b1) : dv_q[i];
            end
        end

        mn = cv[0];
        mx = cv[0];
        for (int i = 1; i < NUM_LANES; i++)
        begin
            if (lt_s(cv[i], mn))
            begin
                mn = cv[i];
            end
            if (lt_s(mx, cv[i]))
            begin
                mx = cv[i];
            end
        end

        res_kind_next = side_out.kind;
        res_lo_next   = side_out.lo;
        res_hi_next   = side_out.hi;
        if (!side_out.fixed)
        begin
            res_kind_next = KIND_UNBOUNDED;
            case (side_out.act)
                ACT_MUL:
                begin
                    if (!ov)
                    begin
                        res_kind_next = KIND_BOUNDED;
                        res_lo_next   = mn;
                        res_hi_next   = mx;
                    end
                end
                ACT_SDIV:
                begin
                    if (side_out.span)
                    begin
                        if (!side_out.m[W-1])
                        begin
                            res_kind_next = KIND_BOUNDED;
                            res_lo_next   = ~side_out.m + 1'b1;
                            res_hi_next   = side_out.m;
                        end
                    end
                    else if (!side_out.dz && !ov)
                    begin
                        res_kind_next = KIND_BOUNDED;
                        res_lo_next   = mn;
                        res_hi_next   = mx;
                    end
                end
                ACT_UDIV:
                begin
                    if (!side_out.dz)
                    begin
                        res_kind_next = KIND_BOUNDED;
                        res_lo_next   = dv_q[1];
                        res_hi_next   = dv_q[2];
                    end
                end
                default:
                begin
                    res_kind_next = KIND_UNBOUNDED;
                end
            endcase
        end
        if (res_kind_next != KIND_BOUNDED)
        begin
            res_lo_next = '0;
            res_hi_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= side_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_kind_reg <= res_kind_next;
            res_lo_reg   <= 32'($signed(res_lo_next));
            res_hi_reg   <= 32'($signed(res_hi_next));
        end
    end

    assign out_valid   = out_vld_reg;
    assign result_kind = res_kind_reg;
    assign result_low  = res_lo_reg;
    assign result_high = res_hi_reg;

endmodule
`default_nettype wire
